// ===== rtl/stateful_packet_filter_defines.svh =====
// Assertion macros for the packet filter
`ifndef STATEFUL_PACKET_FILTER_DEFINES_SVH
`define STATEFUL_PACKET_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPF_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPF_ASSERT(label, prop, msg)
`define SPF_ASSERT_NR(label, prop, msg)
`endif
`endif

// ===== rtl/spf_pkg.sv =====
`default_nettype none
package spf_pkg;
  localparam int unsigned RuleEntries = 16;
  localparam int unsigned FlowEntries = 64;
  localparam int unsigned RuleIdxW = $clog2(RuleEntries);
  localparam int unsigned RuleCntW = $clog2(RuleEntries + 1);
  localparam int unsigned FlowIdxW = $clog2(FlowEntries);
  localparam int unsigned FlowCntW = $clog2(FlowEntries + 1);

  localparam logic [1:0] ProtoTcp = 2'd0;
  localparam logic [1:0] ProtoUdp = 2'd1;
  localparam logic [1:0] ProtoIcmp = 2'd2;
  localparam logic [1:0] ProtoOther = 2'd3;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatRuleFull = 2'd1;
  localparam logic [1:0] StatFlowFull = 2'd2;

  localparam logic [1:0] TcpHalf = 2'd1;
  localparam logic [1:0] TcpConn = 2'd2;
  localparam logic [1:0] TcpClose = 2'd3;

  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;
  localparam int unsigned FlagAck = 4;

  // flow table search request and answer
  typedef struct packed {
    logic        start;
    logic [1:0]  proto;
    logic [63:0] addrs;
    logic [31:0] ports;
  } flow_req_t;

  typedef struct packed {
    logic                done;
    logic                hit;
    logic [FlowIdxW-1:0] hit_idx;
    logic                free;
    logic [FlowIdxW-1:0] free_idx;
    logic [5:0]          info;
  } flow_rsp_t;

  typedef struct packed {
    logic                en;
    logic [FlowIdxW-1:0] idx;
    logic                key_en;
    logic [63:0]         addrs;
    logic [31:0]         ports;
    logic [5:0]          info;
  } flow_wr_t;
endpackage
`default_nettype wire

// ===== rtl/spf_flow_table.sv =====
`default_nettype none
`include "stateful_packet_filter_defines.svh"
module spf_flow_table import spf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire flow_req_t req_i,
  input  wire flow_wr_t  wr_i,
  output flow_rsp_t      rsp_o
);
  logic [63:0] addrs_mem [FlowEntries];
  logic [31:0] ports_mem [FlowEntries];
  logic [FlowEntries-1:0] valid_q;
  logic [5:0] info_q [FlowEntries];

  logic                busy_q, busy_d;
  logic [FlowIdxW-1:0] idx_q, idx_d;
  logic                vld_q, vld_d;
  logic [FlowIdxW-1:0] rd_idx_q;
  logic [63:0]         rd_addrs_q;
  logic [31:0]         rd_ports_q;
  logic [5:0]          rd_info_q;
  logic                last_q, last_d;
  logic [1:0]          proto_q;
  logic [63:0]         addrs_q;
  logic [31:0]         ports_q;
  flow_rsp_t           rsp_q, rsp_d;
  logic                match;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.key_en) begin
      addrs_mem[wr_i.idx] <= wr_i.addrs;
      ports_mem[wr_i.idx] <= wr_i.ports;
    end
    rd_addrs_q <= addrs_mem[idx_q];
    rd_ports_q <= ports_mem[idx_q];
    rd_info_q  <= info_q[idx_q];
    rd_idx_q   <= idx_q;
    if (req_i.start) begin
      proto_q <= req_i.proto;
      addrs_q <= req_i.addrs;
      ports_q <= req_i.ports;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= wr_i.info[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      info_q[wr_i.idx] <= wr_i.info;
    end
  end

  assign match = vld_q && rd_info_q[0] && valid_q[rd_idx_q] && rd_info_q[2:1] == proto_q
                 && rd_addrs_q == addrs_q && rd_ports_q == ports_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    vld_d  = 1'b0;
    last_d = 1'b0;
    rsp_d  = rsp_q;
    rsp_d.done = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      rsp_d.hit = 1'b0;
      rsp_d.free = 1'b0;
    end else if (busy_q) begin
      vld_d  = 1'b1;
      last_d = (idx_q == FlowIdxW'(FlowEntries - 1));
      if (last_d) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (vld_q) begin
      if (!valid_q[rd_idx_q] && !rsp_d.free) begin
        rsp_d.free = 1'b1;
        rsp_d.free_idx = rd_idx_q;
      end
      if (match && !rsp_d.hit) begin
        rsp_d.hit = 1'b1;
        rsp_d.hit_idx = rd_idx_q;
        rsp_d.info = rd_info_q;
      end
      rsp_d.done = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      vld_q  <= 1'b0;
      last_q <= 1'b0;
      rsp_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      vld_q  <= vld_d;
      last_q <= last_d;
      rsp_q  <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  `SPF_ASSERT(a_done_single, rsp_q.done |=> !rsp_q.done, "done held twice")
  `SPF_ASSERT(a_start_idle, req_i.start |-> !busy_q, "search started while busy")
  `SPF_ASSERT(a_hit_valid, rsp_q.done && rsp_q.hit |-> valid_q[rsp_q.hit_idx],
              "hit on invalid entry")
endmodule
`default_nettype wire

// ===== rtl/stateful_packet_filter.sv =====
// Stateful packet filter with connection tracking.
// Input channel s_axis_*: one item per packet to filter or rule to add;
// s_axis_tuser selects the kind (0 filter, 1 add rule). Output channel
// m_axis_*: exactly one result item per input item.
// An item is taken when s_axis_tvalid and s_axis_tready are high; tready
// stays low until the result of that item has been taken.
// After an item is taken the filter passes through SWait; an other-protocol
// packet or a rule add into a full table then goes straight to the output,
// a rule add runs one flow search, UDP/ICMP a flow search and, on a miss,
// the rule search, and TCP a forward search, on a miss a reverse search,
// and then the rule search. Each flow search walks all 64 entries one per
// cycle through the shared compare unit; the rule search checks the rules
// newest first.
// Reset clears the rule count, every flow valid bit and all control state;
// the tables need no clearing pass.
// When the receiver stalls m_axis_tready, the result is held in the output
// register and no new item is taken.
`default_nettype none
`include "stateful_packet_filter_defines.svh"
module stateful_packet_filter import spf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func[0]
  input  wire logic         s_axis_tuser,
  // src_ip[31:0], dst_ip[63:32], sport[79:64], dport[95:80],
  // protocol[97:96], tcp_flags[105:98], rule_pass[106], zeros[111:107]
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // accept[0], status[2:1], zeros[7:3]
  output logic [7:0]        m_axis_tdata
);
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SFwd  = 4'd1;
  localparam logic [3:0] SRev  = 4'd2;
  localparam logic [3:0] SRule = 4'd3;
  localparam logic [3:0] SRuleChk = 4'd4;
  localparam logic [3:0] SDel  = 4'd5;
  localparam logic [3:0] SOut  = 4'd6;
  localparam logic [3:0] SWait = 4'd7;

  logic [3:0] state_q, state_d;
  logic        func_q, pass_q;
  logic [31:0] sip_q, dip_q;
  logic [15:0] sp_q, dp_q;
  logic [1:0]  proto_q;
  logic [7:0]  flags_q;
  logic        in_acc;

  logic [63:0] rule_addrs [RuleEntries];
  logic [31:0] rule_ports [RuleEntries];
  logic [2:0]  rule_kind [RuleEntries];
  logic [RuleCntW-1:0] rule_cnt_q, rule_cnt_d;
  logic [RuleCntW-1:0] rk_q, rk_d;
  logic [63:0] rr_addrs_q;
  logic [31:0] rr_ports_q;
  logic [2:0]  rr_kind_q;
  logic        rule_wr;

  flow_req_t req;
  flow_wr_t  wr;
  flow_rsp_t rsp;
  logic      fwd_hit_q, fwd_hit_d;
  logic      free_q, free_d;
  logic [FlowIdxW-1:0] free_idx_q, free_idx_d;

  logic       acc_q, acc_d;
  logic [1:0] stat_q, stat_d;
  logic       ovld_q, ovld_d;

  logic [31:0] fp, rp;
  logic        syn, ack, fin, rst_f;
  logic        rmatch;
  logic        trk_acc;
  logic [5:0]  trk_info;
  logic        trk_wr;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= s_axis_tuser;
      sip_q   <= s_axis_tdata[31:0];
      dip_q   <= s_axis_tdata[63:32];
      sp_q    <= s_axis_tdata[79:64];
      dp_q    <= s_axis_tdata[95:80];
      proto_q <= s_axis_tdata[97:96];
      flags_q <= s_axis_tdata[105:98];
      pass_q  <= s_axis_tdata[106];
    end
  end

  assign fp = (proto_q == ProtoIcmp) ? 32'd0 : {sp_q, dp_q};
  assign rp = (proto_q == ProtoIcmp) ? 32'd0 : {dp_q, sp_q};
  assign syn = flags_q[FlagSyn];
  assign ack = flags_q[FlagAck];
  assign fin = flags_q[FlagFin];
  assign rst_f = flags_q[FlagRst];

  // rule store and registered read of the newest unchecked rule
  assign rule_wr = (state_q == SDel) && rsp.done;
  always_ff @(posedge clk_i) begin
    if (rule_wr) begin
      rule_addrs[rule_cnt_q[RuleIdxW-1:0]] <= {sip_q, dip_q};
      rule_ports[rule_cnt_q[RuleIdxW-1:0]] <= {sp_q, dp_q};
      rule_kind[rule_cnt_q[RuleIdxW-1:0]]  <= {proto_q, pass_q};
    end
    rr_addrs_q <= rule_addrs[rk_d[RuleIdxW-1:0] - 1'b1];
    rr_ports_q <= rule_ports[rk_d[RuleIdxW-1:0] - 1'b1];
    rr_kind_q  <= rule_kind[rk_d[RuleIdxW-1:0] - 1'b1];
  end

  assign rmatch = rr_kind_q[2:1] == proto_q
    && (rr_addrs_q[63:32] == '0 || rr_addrs_q[63:32] == sip_q)
    && (rr_addrs_q[31:0] == '0 || rr_addrs_q[31:0] == dip_q)
    && (proto_q == ProtoIcmp
        || ((rr_ports_q[31:16] == '0 || rr_ports_q[31:16] == sp_q)
            && (rr_ports_q[15:0] == '0 || rr_ports_q[15:0] == dp_q)));

  // TCP tracking on the hit flow entry
  always_comb begin
    trk_acc  = 1'b0;
    trk_wr   = 1'b0;
    trk_info = rsp.info;
    if (rst_f) begin
      trk_acc = 1'b1; trk_wr = 1'b1; trk_info = '0;
    end else if (rsp.info[4:3] == TcpHalf && !fwd_hit_q && syn && !ack) begin
      trk_acc = fwd_hit_q;
    end else if (rsp.info[4:3] == TcpHalf && fwd_hit_q && syn && !ack) begin
      trk_acc = 1'b1;
    end else if (rsp.info[4:3] == TcpHalf && !fwd_hit_q && syn && ack) begin
      trk_acc = 1'b1; trk_wr = 1'b1;
      trk_info = {1'b0, TcpConn, rsp.info[2:0]};
    end else if (rsp.info[4:3] == TcpConn && !syn && ack && !fin) begin
      trk_acc = 1'b1;
    end else if (rsp.info[4:3] == TcpConn && ack && fin) begin
      trk_acc = 1'b1; trk_wr = 1'b1;
      trk_info = {!fwd_hit_q, TcpClose, rsp.info[2:0]};
    end else if (rsp.info[4:3] == TcpClose && ack && fin && rsp.info[5] == fwd_hit_q) begin
      trk_acc = 1'b1; trk_wr = 1'b1; trk_info = '0;
    end else if (rsp.info[4:3] == TcpClose && ack && !fin) begin
      trk_acc = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    rule_cnt_d = rule_cnt_q;
    rk_d       = rk_q;
    fwd_hit_d  = fwd_hit_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    acc_d      = acc_q;
    stat_d     = stat_q;
    ovld_d     = ovld_q;
    req        = '0;
    wr         = '0;
    req.proto  = proto_q;
    req.addrs  = {sip_q, dip_q};
    req.ports  = fp;
    case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = SWait;
        end
      end
      SWait: begin
        acc_d = 1'b0;
        stat_d = StatOk;
        fwd_hit_d = 1'b1;
        if (func_q) begin
          if (rule_cnt_q >= RuleCntW'(RuleEntries)) begin
            stat_d = StatRuleFull;
            state_d = SOut;
          end else begin
            req.start = 1'b1;
            state_d = SDel;
          end
        end else if (proto_q == ProtoOther) begin
          acc_d = 1'b1;
          state_d = SOut;
        end else begin
          req.start = 1'b1;
          state_d = SFwd;
        end
      end
      SDel: begin
        if (rsp.done) begin
          if (!pass_q && (proto_q == ProtoUdp || proto_q == ProtoIcmp) && rsp.hit) begin
            wr.en = 1'b1;
            wr.idx = rsp.hit_idx;
            wr.info = '0;
          end
          rule_cnt_d = rule_cnt_q + 1'b1;
          state_d = SOut;
        end
      end
      SFwd: begin
        if (rsp.done) begin
          free_d = rsp.free;
          free_idx_d = rsp.free_idx;
          if (rsp.hit) begin
            if (proto_q == ProtoTcp) begin
              acc_d = trk_acc;
              wr.en = trk_wr;
              wr.idx = rsp.hit_idx;
              wr.info = trk_info;
            end else begin
              acc_d = 1'b1;
            end
            state_d = SOut;
          end else if (proto_q == ProtoTcp) begin
            fwd_hit_d = 1'b0;
            req.start = 1'b1;
            req.addrs = {dip_q, sip_q};
            req.ports = rp;
            state_d = SRev;
          end else begin
            rk_d = rule_cnt_q;
            state_d = SRule;
          end
        end
      end
      SRev: begin
        if (rsp.done) begin
          if (rsp.hit) begin
            acc_d = trk_acc;
            wr.en = trk_wr;
            wr.idx = rsp.hit_idx;
            wr.info = trk_info;
            state_d = SOut;
          end else begin
            rk_d = rule_cnt_q;
            state_d = SRule;
          end
        end
      end
      SRule: begin
        // rr_* now holds rule rk_q-1
        if (rk_q == '0) begin
          state_d = SOut;
        end else begin
          state_d = SRuleChk;
        end
      end
      SRuleChk: begin
        if (rmatch) begin
          if (rr_kind_q[0] && (proto_q != ProtoTcp || (syn && !ack))) begin
            if (free_q) begin
              acc_d = 1'b1;
              wr.en = 1'b1;
              wr.key_en = 1'b1;
              wr.idx = free_idx_q;
              wr.addrs = {sip_q, dip_q};
              wr.ports = fp;
              wr.info = {1'b0, (proto_q == ProtoTcp) ? TcpHalf : 2'b00, proto_q, 1'b1};
            end else begin
              stat_d = StatFlowFull;
            end
          end
          state_d = SOut;
        end else begin
          rk_d = rk_q - 1'b1;
          state_d = SRule;
        end
      end
      SOut: begin
        if (!ovld_q) begin
          ovld_d = 1'b1;
        end else if (m_axis_tready) begin
          ovld_d = 1'b0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      rule_cnt_q <= '0;
      rk_q       <= '0;
      fwd_hit_q  <= 1'b0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      acc_q      <= 1'b0;
      stat_q     <= StatOk;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rule_cnt_q <= rule_cnt_d;
      rk_q       <= rk_d;
      fwd_hit_q  <= fwd_hit_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      acc_q      <= acc_d;
      stat_q     <= stat_d;
      ovld_q     <= ovld_d;
    end
  end

  spf_flow_table u_flow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .wr_i   (wr),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {5'd0, stat_q, acc_q};

  `SPF_ASSERT(a_cnt_bound, rule_cnt_q <= RuleCntW'(RuleEntries), "rule count overflow")
  `SPF_ASSERT(a_out_state, m_axis_tvalid |-> state_q == SOut, "result outside output state")
  `SPF_ASSERT(a_no_take_busy, m_axis_tvalid |-> !s_axis_tready, "ready while result pending")
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import spf_pkg::*;

  typedef struct packed {
    logic        rule_pass;
    logic [7:0]  tcp_flags;
    logic [1:0]  protocol;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic        func;
  } filter_item_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] status;
  } verdict_t;

  class verdict_board;
    logic [63:0] r_addr[RuleEntries];
    logic [31:0] r_port[RuleEntries];
    logic        r_pass[RuleEntries];
    logic [1:0]  r_proto[RuleEntries];
    int          r_cnt;
    logic [63:0] f_addr[FlowEntries];
    logic [31:0] f_port[FlowEntries];
    logic [1:0]  f_proto[FlowEntries];
    logic        f_valid[FlowEntries];
    logic [1:0]  f_st[FlowEntries];
    logic        f_finrev[FlowEntries];
    verdict_t    pending[$];
    int          errors;

    function void clear();
      r_cnt = 0;
      errors = 0;
      foreach (f_valid[i]) f_valid[i] = 1'b0;
    endfunction

    function int find_flow(logic [1:0] p, logic [63:0] a, logic [31:0] q);
      for (int i = 0; i < FlowEntries; i++)
        if (f_valid[i] && f_proto[i] == p && f_addr[i] == a && f_port[i] == q) return i;
      return -1;
    endfunction

    function logic track(int e, bit rev, logic [7:0] f);
      logic syn, ack, fin;
      syn = f[FlagSyn]; ack = f[FlagAck]; fin = f[FlagFin];
      if (f[FlagRst]) begin
        f_valid[e] = 0; return 1;
      end
      if (f_st[e] == TcpHalf && !rev && syn && !ack) return 1;
      if (f_st[e] == TcpHalf && rev && syn && ack) begin
        f_st[e] = TcpConn; f_finrev[e] = 0; return 1;
      end
      if (f_st[e] == TcpConn && !syn && ack && !fin) return 1;
      if (f_st[e] == TcpConn && ack && fin) begin
        f_st[e] = TcpClose; f_finrev[e] = rev; return 1;
      end
      if (f_st[e] == TcpClose && ack && fin && f_finrev[e] == !rev) begin
        f_valid[e] = 0; return 1;
      end
      if (f_st[e] == TcpClose && ack && !fin) return 1;
      return 0;
    endfunction

    function void note(filter_item_t it);
      verdict_t v;
      logic [63:0] fa, ra;
      logic [31:0] fp, rp;
      int e, d;
      v = '0;
      fa = {it.src_ip, it.dst_ip};
      ra = {it.dst_ip, it.src_ip};
      fp = {it.sport, it.dport};
      rp = {it.dport, it.sport};
      if (it.protocol == ProtoIcmp) begin
        fp = '0; rp = '0;
      end
      if (it.func) begin
        if (r_cnt >= RuleEntries) v.status = StatRuleFull;
        else begin
          if (!it.rule_pass && (it.protocol == ProtoUdp || it.protocol == ProtoIcmp)) begin
            e = find_flow(it.protocol, fa, fp);
            if (e >= 0) f_valid[e] = 0;
          end
          r_addr[r_cnt] = fa; r_port[r_cnt] = {it.sport, it.dport};
          r_pass[r_cnt] = it.rule_pass; r_proto[r_cnt] = it.protocol;
          r_cnt++;
        end
      end else if (it.protocol == ProtoOther) v.accept = 1;
      else begin
        e = find_flow(it.protocol, fa, fp);
        if (e >= 0) v.accept = (it.protocol == ProtoTcp) ? track(e, 0, it.tcp_flags) : 1'b1;
        else if (it.protocol == ProtoTcp && (e = find_flow(it.protocol, ra, rp)) >= 0)
          v.accept = track(e, 1, it.tcp_flags);
        else begin
          d = -1;
          for (int k = r_cnt - 1; k >= 0 && d < 0; k--) begin
            if (r_proto[k] != it.protocol) continue;
            if (r_addr[k][63:32] != 0 && r_addr[k][63:32] != it.src_ip) continue;
            if (r_addr[k][31:0] != 0 && r_addr[k][31:0] != it.dst_ip) continue;
            if (it.protocol != ProtoIcmp) begin
              if (r_port[k][31:16] != 0 && r_port[k][31:16] != it.sport) continue;
              if (r_port[k][15:0] != 0 && r_port[k][15:0] != it.dport) continue;
            end
            d = r_pass[k];
          end
          if (d == 1 && (it.protocol != ProtoTcp ||
                         (it.tcp_flags[FlagSyn] && !it.tcp_flags[FlagAck]))) begin
            e = -1;
            for (int i = 0; i < FlowEntries && e < 0; i++) if (!f_valid[i]) e = i;
            if (e >= 0) begin
              f_valid[e] = 1; f_addr[e] = fa; f_port[e] = fp; f_proto[e] = it.protocol;
              f_st[e] = (it.protocol == ProtoTcp) ? TcpHalf : 2'd0; f_finrev[e] = 0;
              v.accept = 1;
            end else v.status = StatFlowFull;
          end
        end
      end
      pending.push_back(v);
    endfunction

    function void check(logic [7:0] data);
      verdict_t x;
      if (pending.size() == 0) begin
        $error("unexpected result %h", data); errors++; return;
      end
      x = pending.pop_front();
      if (data[0] !== x.accept) begin
        $error("accept expected %0d actual %0d", x.accept, data[0]); errors++;
      end
      if (data[2:1] !== x.status) begin
        $error("status expected %0d actual %0d", x.status, data[2:1]); errors++;
      end
      if (data[7:3] !== 5'd0) begin
        $error("pad expected 0 actual %0d", data[7:3]); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic s_axis_tuser = 0;
  logic [111:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [7:0] m_axis_tdata;
  int src_idle = 0, snk_idle = 0;
  verdict_board sb = new();

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  stateful_packet_filter dut (.*);

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  logic [31:0] ips[8];
  logic [15:0] ports[4];

  task automatic send(filter_item_t it);
    while ($urandom_range(99) < src_idle) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {5'd0, it.rule_pass, it.tcp_flags, it.protocol, it.dport, it.sport,
                     it.dst_ip, it.src_ip};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note(it);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  function automatic filter_item_t pick(bit rule);
    filter_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(filter_item_t)-1:0];
    it.func = rule;
    if ($urandom_range(9) < 8) begin
      it.src_ip = ($urandom_range(3) == 0 && rule) ? 32'd0 : ips[$urandom_range(7)];
      it.dst_ip = ($urandom_range(3) == 0 && rule) ? 32'd0 : ips[$urandom_range(7)];
      it.sport = ($urandom_range(2) == 0 && rule) ? 16'd0 : ports[$urandom_range(3)];
      it.dport = ($urandom_range(2) == 0 && rule) ? 16'd0 : ports[$urandom_range(3)];
      case ($urandom_range(7))
        0: it.tcp_flags = 8'h02;
        1: it.tcp_flags = 8'h12;
        2: it.tcp_flags = 8'h10;
        3: it.tcp_flags = 8'h11;
        4: it.tcp_flags = 8'h04;
        default: ;
      endcase
    end
    if (rule) it.rule_pass = ($urandom_range(3) != 0);
    return it;
  endfunction

  task automatic flush();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    filter_item_t it;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 0) begin
        flush();
        repeat (200) @(posedge clk_i);
        rst_ni <= 1;
      end
      it = pick($urandom_range(19) == 0);
      send(it);
      if (it.func == 0 && it.protocol == ProtoTcp && $urandom_range(1)) begin
        it.tcp_flags = 8'h12;
        {it.src_ip, it.dst_ip} = {it.dst_ip, it.src_ip};
        {it.sport, it.dport} = {it.dport, it.sport};
        send(it);
      end
    end
  endtask

  initial begin
    filter_item_t it;
    sb.clear();
    foreach (ips[i]) ips[i] = $urandom;
    ips[0] = 32'hFFFF_FFFF;
    foreach (ports[i]) ports[i] = 16'($urandom);
    ports[0] = 16'hFFFF;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    it = '0; it.protocol = ProtoOther; it.tcp_flags = 8'hFF; send(it);
    it = '0; it.func = 1; it.rule_pass = 1; it.protocol = ProtoTcp; send(it);
    it = '0; it.func = 1; it.rule_pass = 1; it.protocol = ProtoUdp; send(it);
    it = '0; it.func = 1; it.rule_pass = 1; it.protocol = ProtoIcmp; send(it);
    it = '0; it.func = 1; it.protocol = ProtoOther; send(it);
    it = '0; it.src_ip = '1; it.dst_ip = 32'd1; it.sport = '1; it.dport = 16'd80;
    it.tcp_flags = 8'h02; send(it);
    it.tcp_flags = 8'h02; send(it);
    {it.src_ip, it.dst_ip} = {it.dst_ip, it.src_ip};
    {it.sport, it.dport} = {it.dport, it.sport};
    it.tcp_flags = 8'h02; send(it);
    it.tcp_flags = 8'h12; send(it);
    it.tcp_flags = 8'h10; send(it);
    it.tcp_flags = 8'h11; send(it);
    it.tcp_flags = 8'h10; send(it);
    {it.src_ip, it.dst_ip} = {it.dst_ip, it.src_ip};
    {it.sport, it.dport} = {it.dport, it.sport};
    it.tcp_flags = 8'h11; send(it);
    it.tcp_flags = 8'h10; send(it);
    it.protocol = ProtoIcmp; it.sport = 16'd5; send(it);
    it.protocol = ProtoUdp; send(it);
    it.func = 1; it.rule_pass = 0; send(it);
    it.func = 0; send(it);
    it.func = 1; it.protocol = ProtoIcmp; it.sport = 16'd7; send(it);
    for (int i = 0; i < FlowEntries + 2; i++) begin
      it = '0; it.protocol = ProtoUdp; it.src_ip = 32'(i); it.dport = 16'($urandom);
      send(it);
    end
    for (int i = 0; i < 8; i++) begin
      it = pick(1); send(it);
    end
    flush();
    src_idle = 35; snk_idle = 77;
    random_phase(600);
    src_idle = 77; snk_idle = 35;
    random_phase(600);
    src_idle = 0; snk_idle = 0;
    random_phase(500);
    flush();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/spf_pkg.sv
rtl/spf_flow_table.sv
rtl/stateful_packet_filter.sv
tb/tb_top.sv
